[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the max tracking stack: operation and
// status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int DEPTH_DEFAULT      = 256;
	localparam int DATA_WIDTH_DEFAULT = 32;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EMPTY_POP = 2'd1,
		STATUS_FULL_PUSH = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP_WAIT
	} state_t;

endpackage

[rtl/max_tracking_stack_unit.sv]
// ----------------------------------------------------------------------------
// max_tracking_stack_unit
// Push, pop, clear and query results are held in the output register.
// Pop with two or more entries: the new top is read from the level memory
// (read data registered) and loaded in ST_POP_WAIT, while input is stalled.
// Throughput: one item per cycle unless out_stall holds or a deep pop waits.
// Reset: stack empty, output register empty; level memory is not cleared.
// ----------------------------------------------------------------------------
module max_tracking_stack_unit #(
	parameter int DEPTH      = mts_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT,
	localparam int CW        = $clog2(DEPTH + 1),
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] popped_value,
	output logic [DATA_WIDTH-1:0] top_max,
	output logic                  max_valid,
	output logic [CW-1:0]         fill_count,
	output logic [1:0]            status
);

	localparam int MW = 2 * DATA_WIDTH;

	mts_pkg::state_t state_q, state_d;

	logic [CW-1:0]         count_q, count_d;
	logic [DATA_WIDTH-1:0] top_val_q, top_val_d;
	logic [DATA_WIDTH-1:0] top_max_q, top_max_d;
	logic                  top_ld;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] popped_q, res_popped;
	logic [DATA_WIDTH-1:0] res_max_q, res_max;
	logic                  max_valid_q, res_max_valid;
	logic [CW-1:0]         fill_q, res_fill;
	mts_pkg::status_t      status_q, res_status;
	logic                  res_ld;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [MW-1:0]         wr_data, rd_data;

	logic                  acc;
	logic [DATA_WIDTH-1:0] push_max;
	logic [DATA_WIDTH-1:0] cur_max;
	logic [AW-1:0]         count_m2;

	mts_mem #(
		.DEPTH (DEPTH),
		.WIDTH (MW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall = (state_q != mts_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign cur_max  = (count_q != '0) ? top_max_q : '0;
	assign count_m2 = AW'(count_q - CW'(2));
	assign push_max = ((count_q != '0) && ($signed(top_max_q) > $signed(value)))
		? top_max_q : value;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		top_val_d     = top_val_q;
		top_max_d     = top_max_q;
		top_ld        = 1'b0;
		res_ld        = 1'b0;
		res_popped    = '0;
		res_max       = cur_max;
		res_max_valid = (count_q != '0);
		res_fill      = count_q;
		res_status    = mts_pkg::STATUS_OK;
		wr_en         = 1'b0;
		wr_addr       = count_q[AW-1:0];
		wr_data       = {push_max, value};
		rd_en         = 1'b0;
		rd_addr       = count_m2;
		case (state_q)
			mts_pkg::ST_IDLE: begin
				if (acc) begin
					res_ld = 1'b1;
					case (mts_pkg::kind_t'(kind))
						mts_pkg::KIND_PUSH: begin
							if (count_q == CW'(DEPTH)) begin
								res_status = mts_pkg::STATUS_FULL_PUSH;
							end else begin
								wr_en         = 1'b1;
								top_ld        = 1'b1;
								top_val_d     = value;
								top_max_d     = push_max;
								count_d       = count_q + CW'(1);
								res_max       = push_max;
								res_max_valid = 1'b1;
								res_fill      = count_q + CW'(1);
							end
						end
						mts_pkg::KIND_POP: begin
							if (count_q == '0) begin
								res_status = mts_pkg::STATUS_EMPTY_POP;
							end else if (count_q == CW'(1)) begin
								count_d       = '0;
								res_popped    = top_val_q;
								res_max       = '0;
								res_max_valid = 1'b0;
								res_fill      = '0;
							end else begin
								res_ld  = 1'b0;
								rd_en   = 1'b1;
								state_d = mts_pkg::ST_POP_WAIT;
							end
						end
						mts_pkg::KIND_CLEAR: begin
							count_d       = '0;
							res_max       = '0;
							res_max_valid = 1'b0;
							res_fill      = '0;
						end
						default: begin
						end
					endcase
				end
			end
			mts_pkg::ST_POP_WAIT: begin
				res_ld        = 1'b1;
				top_ld        = 1'b1;
				top_val_d     = rd_data[DATA_WIDTH-1:0];
				top_max_d     = rd_data[MW-1:DATA_WIDTH];
				count_d       = count_q - CW'(1);
				res_popped    = top_val_q;
				res_max       = rd_data[MW-1:DATA_WIDTH];
				res_max_valid = 1'b1;
				res_fill      = count_q - CW'(1);
				state_d       = mts_pkg::ST_IDLE;
			end
			default: begin
				state_d = mts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (top_ld) begin
			top_val_q <= top_val_d;
			top_max_q <= top_max_d;
		end
		if (res_ld) begin
			popped_q    <= res_popped;
			res_max_q   <= res_max;
			max_valid_q <= res_max_valid;
			fill_q      <= res_fill;
			status_q    <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign top_max      = res_max_q;
	assign max_valid    = max_valid_q;
	assign fill_count   = fill_q;
	assign status       = status_q;

endmodule

[rtl/mts_mem.sv]
// ----------------------------------------------------------------------------
// mts_mem
// Level storage: one write port and one read port, read data registered.
// Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module mts_mem #(
	parameter int DEPTH = mts_pkg::DEPTH_DEFAULT,
	parameter int WIDTH = 2 * mts_pkg::DATA_WIDTH_DEFAULT,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max tracking stack. Items are driven through
// the valid/stall handshake, and each accepted item is run through a local
// stack model that keeps the running maximum at every level. The results
// that come back are compared field by field, in order. The run covers:
// directed corner cases, a fill to full with pushes past the top, a biased
// random walk, and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = mts_pkg::DEPTH_DEFAULT;
	localparam int DW             = mts_pkg::DATA_WIDTH_DEFAULT;
	localparam int CW             = $clog2(DEPTH + 1);
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct {
		logic [DW-1:0]    popped;
		logic [DW-1:0]    top_max;
		logic             max_valid;
		logic [CW-1:0]    fill_count;
		mts_pkg::status_t status;
	} stack_result_t;

	logic          clk        = 1'b0;
	logic          arst_n     = 1'b0;
	logic          in_valid   = 1'b0;
	logic          in_stall;
	logic [1:0]    in_kind    = mts_pkg::KIND_QUERY;
	logic [DW-1:0] in_value   = '0;
	logic          out_valid;
	logic          out_stall  = 1'b0;
	logic [DW-1:0] popped_value;
	logic [DW-1:0] top_max;
	logic          max_valid;
	logic [CW-1:0] fill_count;
	logic [1:0]    status;

	// stack model
	logic signed [DW-1:0] level_val [DEPTH];
	logic signed [DW-1:0] level_max [DEPTH];
	int                   level_count = 0;
	stack_result_t        pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int full_pushes   = 0;
	int empty_pops    = 0;
	int peak_depth    = 0;

	max_tracking_stack_unit #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DW)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (in_kind),
		.value        (in_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.top_max      (top_max),
		.max_valid    (max_valid),
		.fill_count   (fill_count),
		.status       (status)
	);

	always #5 clk = ~clk;

	function automatic void predict_result(mts_pkg::kind_t k, logic signed [DW-1:0] v);
		stack_result_t r;
		r.popped     = '0;
		r.top_max    = '0;
		r.max_valid  = 1'b0;
		r.status     = mts_pkg::STATUS_OK;
		case (k)
			mts_pkg::KIND_PUSH: begin
				if (level_count >= DEPTH) begin
					r.status = mts_pkg::STATUS_FULL_PUSH;
					full_pushes++;
				end else begin
					level_val[level_count] = v;
					if (level_count > 0 && level_max[level_count - 1] > v)
						level_max[level_count] = level_max[level_count - 1];
					else
						level_max[level_count] = v;
					level_count++;
				end
			end
			mts_pkg::KIND_POP: begin
				if (level_count == 0) begin
					r.status = mts_pkg::STATUS_EMPTY_POP;
					empty_pops++;
				end else begin
					level_count--;
					r.popped = level_val[level_count];
				end
			end
			mts_pkg::KIND_CLEAR: level_count = 0;
			default: ;
		endcase
		if (level_count > 0) begin
			r.top_max   = level_max[level_count - 1];
			r.max_valid = 1'b1;
		end
		r.fill_count = level_count[CW-1:0];
		if (level_count > peak_depth)
			peak_depth = level_count;
		pending_results.push_back(r);
	endfunction

	function automatic logic [DW-1:0] rand_value();
		case ($urandom_range(9))
			0: return {1'b0, {(DW-1){1'b1}}};
			1: return {1'b1, {(DW-1){1'b0}}};
			2: return $urandom_range(1) ? '1 : '0;
			3, 4, 5: return DW'(int'($urandom_range(40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(mts_pkg::kind_t k, logic [DW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_kind  <= 2'($urandom_range(3));
			in_value <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_kind  <= k;
		in_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		predict_result(k, v);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic test_directed_ops();
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_QUERY, $urandom);
		send_item(mts_pkg::KIND_CLEAR, $urandom);
		send_item(mts_pkg::KIND_PUSH, '0);
		send_item(mts_pkg::KIND_PUSH, {1'b0, {(DW-1){1'b1}}});
		send_item(mts_pkg::KIND_PUSH, {1'b1, {(DW-1){1'b0}}});
		send_item(mts_pkg::KIND_QUERY, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_PUSH, '1);
		send_item(mts_pkg::KIND_PUSH, DW'(5));
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_PUSH, {1'b1, {(DW-1){1'b0}}});
		send_item(mts_pkg::KIND_PUSH, -DW'(2));
		send_item(mts_pkg::KIND_QUERY, $urandom);
		send_item(mts_pkg::KIND_CLEAR, $urandom);
		send_item(mts_pkg::KIND_QUERY, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_PUSH, DW'(1));
		send_item(mts_pkg::KIND_PUSH, DW'(1));
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
	endtask

	task automatic test_fill_to_full();
		while (level_count < DEPTH)
			send_item(mts_pkg::KIND_PUSH, rand_value());
		repeat (3)
			send_item(mts_pkg::KIND_PUSH, rand_value());
		send_item(mts_pkg::KIND_QUERY, $urandom);
		send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_PUSH, rand_value());
		send_item(mts_pkg::KIND_PUSH, rand_value());
		repeat (DEPTH / 2)
			send_item(mts_pkg::KIND_POP, $urandom);
		send_item(mts_pkg::KIND_CLEAR, $urandom);
		send_item(mts_pkg::KIND_QUERY, $urandom);
	endtask

	task automatic test_random_ops(int n);
		int sent;
		int roll;
		int burst;
		sent = 0;
		while (sent < n) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				burst = $urandom_range(60, 10);
				repeat (burst)
					send_item(mts_pkg::KIND_PUSH, rand_value());
				sent += burst;
			end else if (roll < 9) begin
				burst = $urandom_range(40, 5);
				repeat (burst)
					send_item(mts_pkg::KIND_POP, $urandom);
				sent += burst;
			end else begin
				roll = $urandom_range(99);
				if (roll < 50)
					send_item(mts_pkg::KIND_PUSH, rand_value());
				else if (roll < 82)
					send_item(mts_pkg::KIND_POP, $urandom);
				else if (roll < 97)
					send_item(mts_pkg::KIND_QUERY, $urandom);
				else
					send_item(mts_pkg::KIND_CLEAR, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_output_hold();
		hold_req <= hold_req + 1;
		repeat (40) begin
			if ($urandom_range(3) == 0)
				send_item(mts_pkg::KIND_POP, $urandom);
			else
				send_item(mts_pkg::KIND_PUSH, rand_value());
		end
	endtask

	// receiver side: random stall, or a long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		stack_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result popped=%h top_max=%h fill=%0d status=%0d",
					$time, popped_value, top_max, fill_count, status);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (popped_value !== e.popped) begin
					$display("%0t: popped_value expected %h got %h", $time, e.popped,
						popped_value);
					mismatches++;
				end
				if (top_max !== e.top_max) begin
					$display("%0t: top_max expected %h got %h", $time, e.top_max, top_max);
					mismatches++;
				end
				if (max_valid !== e.max_valid) begin
					$display("%0t: max_valid expected %b got %b", $time, e.max_valid,
						max_valid);
					mismatches++;
				end
				if (fill_count !== e.fill_count) begin
					$display("%0t: fill_count expected %0d got %0d", $time, e.fill_count,
						fill_count);
					mismatches++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0d got %0d", $time, e.status, status);
					mismatches++;
				end
			end
		end
	end

	// no progress on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(27, 76);
		test_directed_ops();
		test_random_ops(80);

		set_idling(76, 27);
		test_fill_to_full();
		test_random_ops(60);

		set_idling(0, 0);
		test_random_ops(60);
		test_output_hold();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			mismatches++;
		end
		$display("sent %0d items, checked %0d results, peak depth %0d of %0d",
			items_sent, results_seen, peak_depth, DEPTH);
		$display("pushes on full stack %0d, pops on empty stack %0d, mismatches %0d",
			full_pushes, empty_pops, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
